/* rtl/mh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_pkg
// Shared constants for the magnetometer heading pipeline: register indexes,
// arctangent table, angle formats and heading correction constants.
// ----------------------------------------------------------------------------
package mh_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y = 4'd1;
    localparam int OFFSET_W = 16;

    // Result channel
    localparam int HEADING_W   = 9;
    localparam int M_TDATA_W   = 16;

    // CORDIC formats
    localparam int TABLE_LEN = 24;
    localparam int PRE_SHIFT = 24;   // samples scaled by 2^24 before the steps
    localparam int ATAN_W    = 22;
    localparam int ZW        = 27;   // degrees, 16 fractional bits, signed
    localparam int HW        = ZW - 8; // degrees, 8 fractional bits, signed

    // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
    localparam logic [ATAN_W-1:0] ATAN_Q16 [TABLE_LEN] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
        22'd234379,  22'd117304,  22'd58666,  22'd29335,
        22'd14668,   22'd7334,    22'd3667,   22'd1833,
        22'd917,     22'd458,     22'd229,    22'd115,
        22'd57,      22'd29,      22'd14,     22'd7,
        22'd4,       22'd2,       22'd1,      22'd0
    };

    localparam logic signed [ZW-1:0] Z_HALF_TURN = 27'sd11796480;  // 180 deg, Q16
    // Q8 rounding bias minus the 90 deg mounting angle, Q16
    localparam logic signed [ZW-1:0] Z_ROUND_MOUNT = -27'sd5898112;
    localparam logic signed [HW-1:0] FULL_Q8     = 19'sd92160;     // 360 deg, Q8
    localparam logic [HEADING_W-1:0] HEADING_ZERO_VEC = 9'd270;

endpackage

/* rtl/magnetometer_heading.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_heading
// Compass heading from one calibrated X/Y magnetometer sample, pipelined
// CORDIC vectoring with one iteration per register stage.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction carries an X and a Y sample in s_tdata.
//   m_* channel: one transaction per input, heading 0..359 in m_tdata.
//   cfg_* channel: writes offset_x (index 0) or offset_y (index 1); other
//   indexes are dropped. cfg_ready is always high; write only while idle.
// Pipeline: a result passes one register for the offset add, one for the
//   half-plane pre-rotation, one per CORDIC iteration and one for the
//   heading correction.
// Throughput: one sample per cycle. Every stage carries a valid bit and
//   advances when the stage after it is empty or advancing, so the pipeline
//   keeps taking samples into empty stages while m_tready is low and only
//   backs up to s_tready once every stage is full. Nothing is dropped.
// Reset: aresetn low clears all valid bits and both offsets to zero.
// ----------------------------------------------------------------------------
module magnetometer_heading #(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16,
    localparam int S_TDATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input samples
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [S_TDATA_W-1:0]            s_tdata,   // x_sample, y_sample, zero fill
    // heading results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mh_pkg::M_TDATA_W-1:0]    m_tdata,   // heading_deg, zero fill
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mh_pkg::OFFSET_W-1:0]     cfg_data
);

    localparam int SB     = SAMPLE_BITS;
    localparam int NSTEPS = (CORDIC_STEPS < mh_pkg::TABLE_LEN) ?
                            CORDIC_STEPS : mh_pkg::TABLE_LEN;
    localparam int CW     = SB + 1;                     // corrected sample
    localparam int RW     = SB + 2;                     // after negation
    localparam int W      = RW + 2 + mh_pkg::PRE_SHIFT; // CORDIC datapath

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [mh_pkg::OFFSET_W-1:0] offset_x_reg;
    logic [mh_pkg::OFFSET_W-1:0] offset_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mh_pkg::REG_OFFSET_X: offset_x_reg <= cfg_data;
                mh_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Offsets are taken at the sample width
    logic signed [SB-1:0] off_x_ext;
    logic signed [SB-1:0] off_y_ext;

    generate
        if (SB <= mh_pkg::OFFSET_W) begin : g_off_trunc
            assign off_x_ext = offset_x_reg[SB-1:0];
            assign off_y_ext = offset_y_reg[SB-1:0];
        end else begin : g_off_zext
            assign off_x_ext = {{(SB - mh_pkg::OFFSET_W){1'b0}}, offset_x_reg};
            assign off_y_ext = {{(SB - mh_pkg::OFFSET_W){1'b0}}, offset_y_reg};
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage ready chain
    // ------------------------------------------------------------------
    logic               a_valid_reg;
    logic [NSTEPS:0]    cv_reg;
    logic               m_valid_reg;
    logic               out_ready;
    logic               a_ready;
    logic [NSTEPS:0]    c_ready;

    assign out_ready       = !m_valid_reg || m_tready;
    assign c_ready[NSTEPS] = !cv_reg[NSTEPS] || out_ready;

    genvar k;
    generate
        for (k = 0; k < NSTEPS; k++) begin : g_ready
            assign c_ready[k] = !cv_reg[k] || c_ready[k+1];
        end
    endgenerate

    assign a_ready  = !a_valid_reg || c_ready[0];
    assign s_tready = a_ready;

    // ------------------------------------------------------------------
    // Stage A: apply calibration offsets
    // ------------------------------------------------------------------
    logic signed [SB-1:0] x_in;
    logic signed [SB-1:0] y_in;
    logic signed [CW-1:0] xc_next;
    logic signed [CW-1:0] yc_next;
    logic signed [CW-1:0] xc_reg;
    logic signed [CW-1:0] yc_reg;

    assign x_in    = s_tdata[SB-1:0];
    assign y_in    = s_tdata[2*SB-1:SB];
    assign xc_next = CW'(x_in) + CW'(off_x_ext);
    assign yc_next = CW'(y_in) + CW'(off_y_ext);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            xc_reg <= xc_next;
            yc_reg <= yc_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: zero test, left half-plane pre-rotation, scaling
    // ------------------------------------------------------------------
    logic signed [W-1:0]          cx_reg [0:NSTEPS];
    logic signed [W-1:0]          cy_reg [0:NSTEPS];
    logic signed [mh_pkg::ZW-1:0] cz_reg [0:NSTEPS];
    logic                         zf_reg [0:NSTEPS];

    logic signed [RW-1:0]          xr;
    logic signed [RW-1:0]          yr;
    logic signed [mh_pkg::ZW-1:0]  z0_next;
    logic                          zero_next;

    always_comb begin
        zero_next = (xc_reg == '0) && (yc_reg == '0);
        if (xc_reg < 0) begin
            xr      = -RW'(xc_reg);
            yr      = -RW'(yc_reg);
            z0_next = (yc_reg >= 0) ? mh_pkg::Z_HALF_TURN : -mh_pkg::Z_HALF_TURN;
        end else begin
            xr      = RW'(xc_reg);
            yr      = RW'(yc_reg);
            z0_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (c_ready[0]) begin
            cv_reg[0] <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready[0]) begin
            cx_reg[0] <= {{2{xr[RW-1]}}, xr, {mh_pkg::PRE_SHIFT{1'b0}}};
            cy_reg[0] <= {{2{yr[RW-1]}}, yr, {mh_pkg::PRE_SHIFT{1'b0}}};
            cz_reg[0] <= z0_next;
            zf_reg[0] <= zero_next;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC stages: one vectoring iteration per stage
    // ------------------------------------------------------------------
    generate
        for (k = 0; k < NSTEPS; k++) begin : g_step
            logic signed [W-1:0]          xs;
            logic signed [W-1:0]          ys;
            logic signed [mh_pkg::ZW-1:0] ang;
            logic signed [W-1:0]          x_next;
            logic signed [W-1:0]          y_next;
            logic signed [mh_pkg::ZW-1:0] z_next;

            assign xs  = cx_reg[k] >>> k;
            assign ys  = cy_reg[k] >>> k;
            assign ang = {{(mh_pkg::ZW - mh_pkg::ATAN_W){1'b0}}, mh_pkg::ATAN_Q16[k]};

            always_comb begin
                if (cy_reg[k] >= 0) begin
                    x_next = cx_reg[k] + ys;
                    y_next = cy_reg[k] - xs;
                    z_next = cz_reg[k] + ang;
                end else begin
                    x_next = cx_reg[k] - ys;
                    y_next = cy_reg[k] + xs;
                    z_next = cz_reg[k] - ang;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    cv_reg[k+1] <= 1'b0;
                end else if (c_ready[k+1]) begin
                    cv_reg[k+1] <= cv_reg[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (c_ready[k+1]) begin
                    cx_reg[k+1] <= x_next;
                    cy_reg[k+1] <= y_next;
                    cz_reg[k+1] <= z_next;
                    zf_reg[k+1] <= zf_reg[k];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output stage: round to Q8, mounting correction, wrap, truncate
    // ------------------------------------------------------------------
    logic signed [mh_pkg::ZW-1:0]  z_rnd;
    logic signed [mh_pkg::HW-1:0]  h_mnt;
    logic signed [mh_pkg::HW-1:0]  h_add;
    logic signed [mh_pkg::HW-1:0]  h_sub;
    logic [mh_pkg::HEADING_W-1:0]  heading_next;
    logic [mh_pkg::HEADING_W-1:0]  heading_reg;

    // Round and mounting correction fold into one add; both wraps run side by side
    always_comb begin
        z_rnd = cz_reg[NSTEPS] + mh_pkg::Z_ROUND_MOUNT;
        h_mnt = z_rnd[mh_pkg::ZW-1:8];
        h_add = h_mnt + mh_pkg::FULL_Q8;
        h_sub = h_mnt - mh_pkg::FULL_Q8;
        if (zf_reg[NSTEPS]) begin
            heading_next = mh_pkg::HEADING_ZERO_VEC;
        end else if (h_mnt < 0) begin
            if (h_add < 0) begin
                heading_next = '0;
            end else begin
                heading_next = h_add[8 + mh_pkg::HEADING_W - 1:8];
            end
        end else if (h_mnt >= mh_pkg::FULL_Q8) begin
            heading_next = h_sub[8 + mh_pkg::HEADING_W - 1:8];
        end else begin
            heading_next = h_mnt[8 + mh_pkg::HEADING_W - 1:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= cv_reg[NSTEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            heading_reg <= heading_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(mh_pkg::M_TDATA_W - mh_pkg::HEADING_W){1'b0}}, heading_reg};

endmodule

/* rtl/mh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh_checker
// Port-level checks for the magnetometer heading block, bound to the top.
// ----------------------------------------------------------------------------
module mh_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [mh_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Heading stays within one turn and the fill bits stay zero
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata < 16'd360))
        else $error("heading out of range");

    // A receiver that takes results never backs up the input
    a_no_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output ready");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind magnetometer_heading mh_checker u_mh_checker (.*);
